### src/gtrm_pkg.sv
// package for the grid tile residency manager
// types, codes and constants shared by controller, datapath and top level; no dependencies
package gtrm_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = IDX_W + 1;
    localparam int WINDOW_RADIUS_MAX = 2;
    localparam int EVICT_EVENTS_MAX = 16;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SET = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [2:0] RES_UNLOADED = 3'd0;
    localparam logic [2:0] RES_QUEUED = 3'd1;
    localparam logic [2:0] RES_RESIDENT = 3'd2;
    localparam logic [2:0] RES_ACTIVE = 3'd3;
    localparam logic [2:0] RES_EVICTING = 3'd4;

    localparam logic [2:0] KIND_OK = 3'd0;
    localparam logic [2:0] KIND_FAIL = 3'd1;
    localparam logic [2:0] KIND_ACTIVATED = 3'd2;
    localparam logic [2:0] KIND_QUEUED = 3'd3;
    localparam logic [2:0] KIND_EVICTED = 3'd4;
    localparam logic [2:0] KIND_SUMMARY = 3'd5;

    localparam logic [2:0] CFG_ACTIVE_RADIUS = 3'd0;
    localparam logic [2:0] CFG_PRELOAD_RADIUS = 3'd1;
    localparam logic [2:0] CFG_UNLOAD_RADIUS = 3'd2;
    localparam logic [2:0] CFG_ACTIVATE_BUDGET = 3'd3;
    localparam logic [2:0] CFG_EVICT_BUDGET = 3'd4;

    localparam logic [47:0] BYTES_MAX48 = {48{1'b1}};
    localparam logic [55:0] BYTES_MAX56 = {56{1'b1}};

    typedef struct packed {
        logic [1:0]  op;
        logic signed [15:0] tile_x;
        logic signed [15:0] tile_z;
        logic [3:0]  tile_lod;
        logic [31:0] asset_bytes;
        logic        asset_valid;
        logic [2:0]  new_residency;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic signed [15:0] out_x;
        logic signed [15:0] out_z;
        logic [3:0]  out_lod;
        logic [8:0]  active_count;
        logic [8:0]  resident_count;
        logic [8:0]  queued_count;
        logic [8:0]  evicting_count;
        logic [8:0]  unloaded_count;
        logic [55:0] resident_bytes;
        logic        budget_limited;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [1:0] active_radius;
        logic [1:0] preload_radius;
        logic [9:0] unload_radius;
        logic [6:0] activate_budget;
        logic [4:0] evict_budget;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic       latch_in;     // capture input item and derived limits
        logic       win_start;    // window offset to the first position
        logic       win_next;     // advance window offset
        logic       scan_start;   // entry pointer to 0
        logic       scan_next;    // advance entry pointer
        logic       rd_issue;     // read entry at pointer
        logic       key_sel_win;  // compare key: window tile vs input key
        logic       append;       // create tile at tile_count with compare key
        logic       add_bytes;    // add bytes to matched entry
        logic       set_res;      // set residency of matched entry
        logic       win_apply;    // apply window rule to matched entry
        logic       evict_apply;  // apply eviction rule to read entry
        logic       count_apply;  // accumulate counts from read entry
        logic       clear_tab;    // tile_count to zero
        logic       clr_stats;    // clear update counters
        logic       set_limited;  // full table during window
        logic [2:0] emit_kind;    // kind for a direct result
        logic       emit;         // load output with a direct result
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic match;       // read entry key equals compare key
        logic scan_end;    // pointer reached tile_count
        logic full;        // tile_count at capacity
        logic win_last;    // window offset at last position
        logic bad_res;     // residency code out of range
        logic asset_ok;    // asset_valid
        logic [1:0] op;    // latched op
        logic event_pend;  // an event waits to be emitted
        logic out_busy;    // output register holds a beat
    } ctl_sts_t;

endpackage

### src/gtrm_datapath.sv
// datapath of the grid tile residency manager: tile table memories, window walk,
// eviction and count logic, output register; uses gtrm_pkg
module gtrm_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gtrm_pkg::in_item_t   in_item,
    input  gtrm_pkg::cfg_t       cfg,
    input  gtrm_pkg::ctl_cmd_t   cmd,
    output gtrm_pkg::ctl_sts_t   sts,
    output gtrm_pkg::out_item_t  out_item,
    output logic                 out_valid,
    input  logic                 out_ready
);

    localparam int IW = gtrm_pkg::IDX_W;
    localparam int CW = gtrm_pkg::CNT_W;

    logic [35:0] coords_mem [gtrm_pkg::TABLE_ENTRIES];
    logic [2:0]  res_mem    [gtrm_pkg::TABLE_ENTRIES];
    logic [47:0] bytes_mem  [gtrm_pkg::TABLE_ENTRIES];

    logic [CW-1:0] count_reg;
    logic [CW-1:0] ptr_reg;
    logic [IW-1:0] hit_reg;
    logic [35:0] rd_key_reg;
    logic [2:0]  rd_res_reg;
    logic [47:0] rd_bytes_reg;
    logic [IW-1:0] rd_idx_reg;

    gtrm_pkg::in_item_t in_reg;
    logic [1:0]  a_reg;
    logic [1:0]  p_reg;
    logic [9:0]  u_reg;
    logic [6:0]  abud_reg;
    logic [4:0]  ebud_reg;
    logic signed [2:0] dx_reg;
    logic signed [2:0] dz_reg;
    logic [6:0]  nact_reg;
    logic [4:0]  nevict_reg;
    logic        limited_reg;
    logic [8:0]  cnt_reg [5];
    logic [55:0] sum_reg;

    logic        ev_pend_reg;
    logic [2:0]  ev_kind_reg;
    logic [35:0] ev_key_reg;
    gtrm_pkg::out_item_t out_reg;
    gtrm_pkg::out_item_t out_next;
    logic        out_valid_reg;

    logic [15:0] wx;
    logic [15:0] wz;
    logic [35:0] win_key;
    logic [35:0] cmp_key;
    logic [IW-1:0] ptr_idx;
    logic [IW-1:0] cnt_idx;
    logic [2:0]  cur_res;
    logic        in_active;
    logic        in_unload;
    logic [1:0]  p_eff;
    logic [48:0] bsum;
    logic [56:0] tsum;

    function automatic logic [15:0] wdist(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return d[15] ? 16'(-d) : d;
    endfunction

    assign ptr_idx = ptr_reg[IW-1:0];
    assign cnt_idx = count_reg[IW-1:0];
    assign wx = 16'(in_reg.tile_x) + 16'(signed'(dx_reg));
    assign wz = 16'(in_reg.tile_z) + 16'(signed'(dz_reg));
    assign win_key = {4'd0, wz, wx};
    assign cmp_key = cmd.key_sel_win ? win_key
                   : {in_reg.tile_lod, 16'(in_reg.tile_z), 16'(in_reg.tile_x)};
    assign in_active = (wdist(wx, 16'(in_reg.tile_x)) <= 16'(a_reg))
                    && (wdist(wz, 16'(in_reg.tile_z)) <= 16'(a_reg));
    assign in_unload = (rd_key_reg[35:32] == 4'd0)
                    && (wdist(rd_key_reg[15:0], 16'(in_reg.tile_x)) <= 16'(u_reg))
                    && (wdist(rd_key_reg[31:16], 16'(in_reg.tile_z)) <= 16'(u_reg));
    // a freshly appended tile reads as unloaded through the hit path
    assign cur_res = rd_res_reg;
    assign p_eff = (cfg.preload_radius > cfg.active_radius) ? cfg.preload_radius
                                                              : cfg.active_radius;
    assign bsum = {1'b0, rd_bytes_reg} + {17'd0, in_reg.asset_bytes};
    assign tsum = {1'b0, sum_reg} + {9'd0, rd_bytes_reg};

    // memory writes and reads
    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            rd_key_reg   <= coords_mem[ptr_idx];
            rd_res_reg   <= res_mem[ptr_idx];
            rd_bytes_reg <= bytes_mem[ptr_idx];
            rd_idx_reg   <= ptr_idx;
        end
        else if (cmd.append)
        begin
            rd_res_reg   <= gtrm_pkg::RES_UNLOADED;
            rd_bytes_reg <= '0;
        end
        if (cmd.append)
        begin
            coords_mem[cnt_idx] <= cmp_key;
            res_mem[cnt_idx]    <= gtrm_pkg::RES_UNLOADED;
            bytes_mem[cnt_idx]  <= '0;
        end
        else if (cmd.add_bytes)
        begin
            bytes_mem[hit_reg] <= bsum[48] ? gtrm_pkg::BYTES_MAX48 : bsum[47:0];
        end
        else if (cmd.set_res)
        begin
            res_mem[hit_reg] <= in_reg.new_residency;
        end
        else if (cmd.win_apply)
        begin
            if (in_active)
            begin
                if (cur_res != gtrm_pkg::RES_ACTIVE)
                begin
                    res_mem[hit_reg] <= (nact_reg < abud_reg) ? gtrm_pkg::RES_ACTIVE
                                                              : gtrm_pkg::RES_QUEUED;
                end
            end
            else if (cur_res == gtrm_pkg::RES_UNLOADED || cur_res == gtrm_pkg::RES_EVICTING)
            begin
                res_mem[hit_reg] <= gtrm_pkg::RES_QUEUED;
            end
        end
        else if (cmd.evict_apply)
        begin
            if (!in_unload && rd_res_reg != gtrm_pkg::RES_UNLOADED)
            begin
                res_mem[rd_idx_reg] <= (nevict_reg < ebud_reg) ? gtrm_pkg::RES_UNLOADED
                                                               : gtrm_pkg::RES_EVICTING;
            end
        end
    end

    // payload latches
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            in_reg   <= in_item;
            a_reg    <= cfg.active_radius;
            p_reg    <= (p_eff > 2'(gtrm_pkg::WINDOW_RADIUS_MAX))
                        ? 2'(gtrm_pkg::WINDOW_RADIUS_MAX) : p_eff;
            abud_reg <= (cfg.activate_budget == 7'd0) ? 7'd1 : cfg.activate_budget;
            ebud_reg <= (cfg.evict_budget == 5'd0) ? 5'd1
                      : (cfg.evict_budget > 5'(gtrm_pkg::EVICT_EVENTS_MAX))
                        ? 5'(gtrm_pkg::EVICT_EVENTS_MAX) : cfg.evict_budget;
        end
        if (cmd.win_start)
        begin
            u_reg  <= (cfg.unload_radius > {8'd0, p_reg}) ? cfg.unload_radius : {8'd0, p_reg};
            dx_reg <= -signed'({1'b0, p_reg});
            dz_reg <= -signed'({1'b0, p_reg});
        end
        else if (cmd.win_next)
        begin
            if (dx_reg == signed'({1'b0, p_reg}))
            begin
                dx_reg <= -signed'({1'b0, p_reg});
                dz_reg <= dz_reg + 3'sd1;
            end
            else
            begin
                dx_reg <= dx_reg + 3'sd1;
            end
        end
        if (cmd.rd_issue || cmd.append)
        begin
            hit_reg <= cmd.append ? cnt_idx : ptr_idx;
        end
    end

    // control counters and stats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ptr_reg     <= '0;
            nact_reg    <= '0;
            nevict_reg  <= '0;
            limited_reg <= 1'b0;
            sum_reg     <= '0;
            for (int k = 0; k < 5; k++)
            begin
                cnt_reg[k] <= '0;
            end
            ev_pend_reg <= 1'b0;
            ev_kind_reg <= gtrm_pkg::KIND_OK;
            ev_key_reg  <= '0;
        end
        else
        begin
            if (cmd.clear_tab)
            begin
                count_reg <= '0;
            end
            else if (cmd.append)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.scan_start)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.scan_next)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (cmd.clr_stats)
            begin
                nact_reg    <= '0;
                nevict_reg  <= '0;
                limited_reg <= 1'b0;
                sum_reg     <= '0;
                for (int k = 0; k < 5; k++)
                begin
                    cnt_reg[k] <= '0;
                end
            end
            if (cmd.set_limited)
            begin
                limited_reg <= 1'b1;
            end
            if (ev_pend_reg && !out_valid_reg)
            begin
                ev_pend_reg <= 1'b0;
            end
            if (cmd.win_apply)
            begin
                if (in_active)
                begin
                    if (cur_res != gtrm_pkg::RES_ACTIVE)
                    begin
                        ev_pend_reg <= 1'b1;
                        ev_key_reg  <= win_key;
                        if (nact_reg < abud_reg)
                        begin
                            nact_reg    <= nact_reg + 1'b1;
                            ev_kind_reg <= gtrm_pkg::KIND_ACTIVATED;
                        end
                        else
                        begin
                            limited_reg <= 1'b1;
                            ev_kind_reg <= gtrm_pkg::KIND_QUEUED;
                        end
                    end
                end
                else if (cur_res == gtrm_pkg::RES_UNLOADED
                         || cur_res == gtrm_pkg::RES_EVICTING)
                begin
                    ev_pend_reg <= 1'b1;
                    ev_key_reg  <= win_key;
                    ev_kind_reg <= gtrm_pkg::KIND_QUEUED;
                end
            end
            if (cmd.evict_apply && !in_unload && rd_res_reg != gtrm_pkg::RES_UNLOADED)
            begin
                if (nevict_reg < ebud_reg)
                begin
                    nevict_reg  <= nevict_reg + 1'b1;
                    ev_pend_reg <= 1'b1;
                    ev_key_reg  <= rd_key_reg;
                    ev_kind_reg <= gtrm_pkg::KIND_EVICTED;
                end
                else
                begin
                    limited_reg <= 1'b1;
                end
            end
            if (cmd.count_apply && rd_res_reg <= gtrm_pkg::RES_EVICTING)
            begin
                if (cnt_reg[rd_res_reg] != 9'h1FF)
                begin
                    cnt_reg[rd_res_reg] <= cnt_reg[rd_res_reg] + 1'b1;
                end
                if (rd_res_reg == gtrm_pkg::RES_ACTIVE || rd_res_reg == gtrm_pkg::RES_RESIDENT)
                begin
                    sum_reg <= tsum[56] ? gtrm_pkg::BYTES_MAX56 : tsum[55:0];
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_valid_reg)
        begin
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else if (ev_pend_reg || cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
    end

    // next beat: a pending event goes first, else the direct result
    always_comb
    begin
        out_next = '0;
        if (ev_pend_reg)
        begin
            out_next.kind    = ev_kind_reg;
            out_next.out_x   = signed'(ev_key_reg[15:0]);
            out_next.out_z   = signed'(ev_key_reg[31:16]);
            out_next.out_lod = ev_key_reg[35:32];
        end
        else
        begin
            out_next.kind  = cmd.emit_kind;
            out_next.out_x = in_reg.tile_x;
            out_next.out_z = in_reg.tile_z;
            out_next.last  = 1'b1;
            if (cmd.emit_kind == gtrm_pkg::KIND_SUMMARY)
            begin
                out_next.out_lod        = 4'd0;
                out_next.active_count   = cnt_reg[gtrm_pkg::RES_ACTIVE];
                out_next.resident_count = cnt_reg[gtrm_pkg::RES_RESIDENT];
                out_next.queued_count   = cnt_reg[gtrm_pkg::RES_QUEUED];
                out_next.evicting_count = cnt_reg[gtrm_pkg::RES_EVICTING];
                out_next.unloaded_count = cnt_reg[gtrm_pkg::RES_UNLOADED];
                out_next.resident_bytes = sum_reg;
                out_next.budget_limited = limited_reg;
            end
            else
            begin
                out_next.out_lod = in_reg.tile_lod;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg && (ev_pend_reg || cmd.emit))
        begin
            out_reg <= out_next;
        end
    end

    assign out_item  = out_reg;
    assign out_valid = out_valid_reg;

    assign sts.match      = (rd_key_reg == cmp_key);
    assign sts.scan_end   = (ptr_reg == count_reg);
    assign sts.full       = (count_reg == CW'(gtrm_pkg::TABLE_ENTRIES));
    assign sts.win_last   = (dx_reg == signed'({1'b0, p_reg}))
                         && (dz_reg == signed'({1'b0, p_reg}));
    assign sts.bad_res    = (in_reg.new_residency > gtrm_pkg::RES_EVICTING);
    assign sts.asset_ok   = in_reg.asset_valid;
    assign sts.op         = in_reg.op;
    assign sts.event_pend = ev_pend_reg;
    assign sts.out_busy   = out_valid_reg;

endmodule

### src/gtrm_ctrl.sv
// controller state machine of the grid tile residency manager
// sequences lookups, window walk, eviction and count scans; uses gtrm_pkg
module gtrm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gtrm_pkg::ctl_sts_t  sts,
    output gtrm_pkg::ctl_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_FIND_RD  = 4'd2;
    localparam logic [3:0] S_FIND_CMP = 4'd3;
    localparam logic [3:0] S_ACT      = 4'd4;
    localparam logic [3:0] S_EMIT     = 4'd5;
    localparam logic [3:0] S_WIN_APPLY = 4'd6;
    localparam logic [3:0] S_WIN_NEXT = 4'd7;
    localparam logic [3:0] S_EV_RD    = 4'd8;
    localparam logic [3:0] S_EV_APPLY = 4'd9;
    localparam logic [3:0] S_CN_RD    = 4'd10;
    localparam logic [3:0] S_CN_APPLY = 4'd11;
    localparam logic [3:0] S_SUMMARY  = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [2:0] kind_reg;
    logic [2:0] kind_next;
    logic       is_win;

    assign is_win = (sts.op == gtrm_pkg::OP_UPDATE);
    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= gtrm_pkg::KIND_OK;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd = '0;
        cmd.key_sel_win = is_win;
        cmd.emit_kind = kind_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.scan_start = 1'b1;
                case (sts.op)
                    gtrm_pkg::OP_ADD:
                    begin
                        if (!sts.asset_ok)
                        begin
                            kind_next = gtrm_pkg::KIND_FAIL;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_FIND_RD;
                        end
                    end
                    gtrm_pkg::OP_SET:
                    begin
                        if (sts.bad_res)
                        begin
                            kind_next = gtrm_pkg::KIND_FAIL;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_FIND_RD;
                        end
                    end
                    gtrm_pkg::OP_CLEAR:
                    begin
                        cmd.clear_tab = 1'b1;
                        kind_next = gtrm_pkg::KIND_OK;
                        state_next = S_EMIT;
                    end
                    default:
                    begin
                        cmd.win_start = 1'b1;
                        cmd.clr_stats = 1'b1;
                        state_next = S_FIND_RD;
                    end
                endcase
            end
            S_FIND_RD:
            begin
                if (sts.scan_end)
                begin
                    if (sts.op == gtrm_pkg::OP_SET || sts.full)
                    begin
                        if (is_win)
                        begin
                            cmd.set_limited = 1'b1;
                            state_next = S_WIN_NEXT;
                        end
                        else
                        begin
                            kind_next = gtrm_pkg::KIND_FAIL;
                            state_next = S_EMIT;
                        end
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                        state_next = S_ACT;
                    end
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    cmd.scan_next = 1'b1;
                    state_next = S_FIND_CMP;
                end
            end
            S_FIND_CMP:
            begin
                state_next = sts.match ? S_ACT : S_FIND_RD;
            end
            S_ACT:
            begin
                if (is_win)
                begin
                    state_next = S_WIN_APPLY;
                end
                else
                begin
                    cmd.add_bytes = (sts.op == gtrm_pkg::OP_ADD);
                    cmd.set_res = (sts.op == gtrm_pkg::OP_SET);
                    kind_next = gtrm_pkg::KIND_OK;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WIN_APPLY:
            begin
                // one event register: wait until the previous event has moved out
                if (!sts.event_pend)
                begin
                    cmd.win_apply = 1'b1;
                    state_next = S_WIN_NEXT;
                end
            end
            S_WIN_NEXT:
            begin
                cmd.scan_start = 1'b1;
                if (sts.win_last)
                begin
                    state_next = S_EV_RD;
                end
                else
                begin
                    cmd.win_next = 1'b1;
                    state_next = S_FIND_RD;
                end
            end
            S_EV_RD:
            begin
                if (sts.scan_end)
                begin
                    cmd.scan_start = 1'b1;
                    state_next = S_CN_RD;
                end
                else if (!sts.event_pend)
                begin
                    cmd.rd_issue = 1'b1;
                    cmd.scan_next = 1'b1;
                    state_next = S_EV_APPLY;
                end
            end
            S_EV_APPLY:
            begin
                cmd.evict_apply = 1'b1;
                state_next = S_EV_RD;
            end
            S_CN_RD:
            begin
                if (sts.scan_end)
                begin
                    state_next = S_SUMMARY;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    cmd.scan_next = 1'b1;
                    state_next = S_CN_APPLY;
                end
            end
            S_CN_APPLY:
            begin
                cmd.count_apply = 1'b1;
                state_next = S_CN_RD;
            end
            S_SUMMARY:
            begin
                cmd.emit_kind = gtrm_pkg::KIND_SUMMARY;
                if (!sts.out_busy && !sts.event_pend)
                begin
                    cmd.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### src/grid_tile_residency_manager_top.sv
// top level of the grid tile residency manager
// joins gtrm_ctrl and gtrm_datapath, holds the configuration registers; uses gtrm_pkg
//
// add and set search the stored tiles linearly, clear resets the tile count;
// an update searches the table once per window tile (up to 25), then makes two passes
// over the table, one for eviction and one for the counts
// throughput: one item at a time; the linear table search on the single read port sets it
// reset: tile count to zero, registers to their reset values, no clearing pass
module grid_tile_residency_manager_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gtrm_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gtrm_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [9:0]           cfg_data
);

    gtrm_pkg::cfg_t     cfg_reg;
    gtrm_pkg::ctl_cmd_t cmd;
    gtrm_pkg::ctl_sts_t sts;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_radius   <= 2'd1;
            cfg_reg.preload_radius  <= 2'd2;
            cfg_reg.unload_radius   <= 10'd3;
            cfg_reg.activate_budget <= 7'd16;
            cfg_reg.evict_budget    <= 5'd16;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gtrm_pkg::CFG_ACTIVE_RADIUS:   cfg_reg.active_radius   <= cfg_data[1:0];
                gtrm_pkg::CFG_PRELOAD_RADIUS:  cfg_reg.preload_radius  <= cfg_data[1:0];
                gtrm_pkg::CFG_UNLOAD_RADIUS:   cfg_reg.unload_radius   <= cfg_data;
                gtrm_pkg::CFG_ACTIVATE_BUDGET: cfg_reg.activate_budget <= cfg_data[6:0];
                gtrm_pkg::CFG_EVICT_BUDGET:    cfg_reg.evict_budget    <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    // sequencer
    gtrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // tables and result register
    gtrm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_data),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .sts       (sts),
        .out_item  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule
